/* design/bcd_countdown_timer_with_alarm_macros.svh */
// Assertion macros shared by the checker
`ifndef BCD_COUNTDOWN_TIMER_WITH_ALARM_MACROS_SVH
`define BCD_COUNTDOWN_TIMER_WITH_ALARM_MACROS_SVH

// Check that b holds in the cycle after a.
`define BCDT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: a then b");

// Check that b holds in the same cycle as a.
`define BCDT_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: a implies b");

`endif

/* design/bcdt_pkg.sv */
package bcdt_pkg;

   typedef struct packed {
      logic       kind;
      logic [3:0] button_code;
   } req_type;

   typedef struct packed {
      logic [3:0] minute_units;
      logic [2:0] minute_tens;
      logic [3:0] hour_units;
      logic [3:0] hour_tens;
      logic       display_visible;
      logic       counting;
      logic       alarm_active;
      logic       hours_selected;
   } rsp_type;

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam int TpmWidth     = 6;

   localparam logic [TpmWidth-1:0] TPM_RESET = 6'd60;

   // register index, taken from the word address
   localparam logic REG_TPM = 1'b0;

   localparam logic [3:0] BTN_MINUTES = 4'd1;
   localparam logic [3:0] BTN_HOURS   = 4'd2;
   localparam logic [3:0] BTN_START   = 4'd3;
   localparam logic [3:0] BTN_DOWN    = 4'd4;
   localparam logic [3:0] BTN_UP      = 4'd8;

   localparam logic [3:0] UNITS_MAX       = 4'd9;
   localparam logic [2:0] MINUTE_TENS_MAX = 3'd5;
   localparam logic [3:0] HOUR_TENS_MAX   = 4'd9;

endpackage

/* design/bcdt_csr.sv */
module bcdt_csr
   import bcdt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output logic [TpmWidth-1:0]     tpm
);

   logic [TpmWidth-1:0] tpm_ff;
   logic [TpmWidth-1:0] tpm_in;
   logic                wr_en;
   logic                hit_tpm;

   assign csr_pready = 1'b1;
   assign hit_tpm    = (csr_paddr[CsrAddrWidth-1] == REG_TPM);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready & hit_tpm;
   assign tpm_in     = wr_en ? csr_pwdata[TpmWidth-1:0] : tpm_ff;
   assign tpm        = tpm_ff;

   always_comb begin
      csr_prdata = '0;
      if (hit_tpm) begin
         csr_prdata = {{(CsrDataWidth-TpmWidth){1'b0}}, tpm_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff <= TPM_RESET;
      end else begin
         tpm_ff <= tpm_in;
      end
   end

endmodule

/* design/bcdt_core.sv */
module bcdt_core
   import bcdt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  req_type             item,
   input  logic [TpmWidth-1:0] tpm,
   output rsp_type             result
);

   logic [3:0]          mu_ff, mu_in;
   logic [2:0]          mt_ff, mt_in;
   logic [3:0]          hu_ff, hu_in;
   logic [3:0]          ht_ff, ht_in;
   logic [14:0]         saved_ff, saved_in;
   logic                hour_ff, hour_in;
   logic                cnt_ff, cnt_in;
   logic                exp_ff, exp_in;
   logic [TpmWidth-1:0] tick_ff, tick_in;
   logic                blink_ff, blink_in;
   logic [TpmWidth-1:0] tick_next;
   logic                all_zero;

   assign all_zero  = (mu_ff == 4'd0) && (mt_ff == 3'd0) && (hu_ff == 4'd0) && (ht_ff == 4'd0);
   assign tick_next = tick_ff + {{(TpmWidth-1){1'b0}}, 1'b1};

   always_comb begin
      mu_in    = mu_ff;
      mt_in    = mt_ff;
      hu_in    = hu_ff;
      ht_in    = ht_ff;
      saved_in = saved_ff;
      hour_in  = hour_ff;
      cnt_in   = cnt_ff;
      exp_in   = exp_ff;
      tick_in  = tick_ff;
      blink_in = blink_ff;
      if (step) begin
         if (!cnt_ff) begin
            if (item.kind) begin
               blink_in = !blink_ff;
            end else begin
               case (item.button_code)
                  BTN_MINUTES: hour_in = 1'b0;
                  BTN_HOURS:   hour_in = 1'b1;
                  BTN_DOWN: begin
                     if (hour_ff) begin
                        if (hu_ff == 4'd0) begin
                           hu_in = UNITS_MAX;
                           ht_in = (ht_ff == 4'd0) ? HOUR_TENS_MAX : ht_ff - 4'd1;
                        end else begin
                           hu_in = hu_ff - 4'd1;
                        end
                     end else begin
                        if (mu_ff == 4'd0) begin
                           mu_in = UNITS_MAX;
                           mt_in = (mt_ff == 3'd0) ? MINUTE_TENS_MAX : mt_ff - 3'd1;
                        end else begin
                           mu_in = mu_ff - 4'd1;
                        end
                     end
                  end
                  BTN_UP: begin
                     if (hour_ff) begin
                        if (hu_ff >= UNITS_MAX) begin
                           hu_in = 4'd0;
                           ht_in = (ht_ff >= HOUR_TENS_MAX) ? 4'd0 : ht_ff + 4'd1;
                        end else begin
                           hu_in = hu_ff + 4'd1;
                        end
                     end else begin
                        if (mu_ff >= UNITS_MAX) begin
                           mu_in = 4'd0;
                           mt_in = (mt_ff >= MINUTE_TENS_MAX) ? 3'd0 : mt_ff + 3'd1;
                        end else begin
                           mu_in = mu_ff + 4'd1;
                        end
                     end
                  end
                  BTN_START: begin
                     saved_in = {ht_ff, hu_ff, mt_ff, mu_ff};
                     cnt_in   = 1'b1;
                     exp_in   = 1'b0;
                     tick_in  = '0;
                     blink_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end else if (!item.kind) begin
            if (item.button_code == BTN_START) begin
               mu_in    = saved_ff[3:0];
               mt_in    = saved_ff[6:4];
               hu_in    = saved_ff[10:7];
               ht_in    = saved_ff[14:11];
               cnt_in   = 1'b0;
               exp_in   = 1'b0;
               tick_in  = '0;
               blink_in = 1'b0;
            end
         end else if (exp_ff) begin
            blink_in = !blink_ff;
         end else if (all_zero) begin
            // alarm on at once
            exp_in   = 1'b1;
            blink_in = 1'b0;
         end else if (tick_next >= tpm) begin
            tick_in = '0;
            // subtract one minute, borrow through the digits
            if (mu_ff != 4'd0) begin
               mu_in = mu_ff - 4'd1;
            end else begin
               mu_in = UNITS_MAX;
               if (mt_ff != 3'd0) begin
                  mt_in = mt_ff - 3'd1;
               end else begin
                  mt_in = MINUTE_TENS_MAX;
                  if (hu_ff != 4'd0) begin
                     hu_in = hu_ff - 4'd1;
                  end else begin
                     hu_in = UNITS_MAX;
                     ht_in = (ht_ff == 4'd0) ? HOUR_TENS_MAX : ht_ff - 4'd1;
                  end
               end
            end
         end else begin
            tick_in = tick_next;
         end
      end
   end

   always_comb begin
      result.minute_units    = mu_in;
      result.minute_tens     = mt_in;
      result.hour_units      = hu_in;
      result.hour_tens       = ht_in;
      result.display_visible = cnt_in | !blink_in;
      result.counting        = cnt_in;
      result.alarm_active    = exp_in & !blink_in;
      result.hours_selected  = hour_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff    <= '0;
         mt_ff    <= '0;
         hu_ff    <= '0;
         ht_ff    <= '0;
         saved_ff <= '0;
         hour_ff  <= 1'b0;
         cnt_ff   <= 1'b0;
         exp_ff   <= 1'b0;
         tick_ff  <= '0;
         blink_ff <= 1'b0;
      end else begin
         mu_ff    <= mu_in;
         mt_ff    <= mt_in;
         hu_ff    <= hu_in;
         ht_ff    <= ht_in;
         saved_ff <= saved_in;
         hour_ff  <= hour_in;
         cnt_ff   <= cnt_in;
         exp_ff   <= exp_in;
         tick_ff  <= tick_in;
         blink_ff <= blink_in;
      end
   end

endmodule

/* design/bcd_countdown_timer_with_alarm.sv */
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   req_data   (bcdt_pkg::req_type)
// rsp_      out        rsp_valid/rsp_ready   rsp_data   (bcdt_pkg::rsp_type)
// csr_      in         APB, pready tied high ticks_per_minute at byte address 0
//
// One transaction per cycle while req_ready is high; its result, taken from the
// combinational state update, appears in the output register on the next cycle.
// req_ready is low only while a result waits and rsp_ready is low.
// Synchronous reset clears the digits, mode flags, tick count and output valid,
// and sets ticks_per_minute to 60.
module bcd_countdown_timer_with_alarm
   import bcdt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                accept;
   logic [TpmWidth-1:0] tpm;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   bcdt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .tpm         (tpm)
   );

   bcdt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .item   (req_data),
      .tpm    (tpm),
      .result (rsp_data_in)
   );

   // hold the result until taken, load on every accepted transaction
   assign rsp_valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/bcdt_checker.sv */
`include "bcd_countdown_timer_with_alarm_macros.svh"

module bcdt_checker
   import bcdt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `BCDT_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_valid && req_ready, rsp_valid)
   `BCDT_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `BCDT_ASSERT_NOW(a_alarm_counting, clock, reset, rsp_valid && rsp_data.alarm_active, rsp_data.counting && rsp_data.display_visible)
   `BCDT_ASSERT_NOW(a_minutes_bcd, clock, reset, rsp_valid, (rsp_data.minute_units <= UNITS_MAX) && (rsp_data.minute_tens <= MINUTE_TENS_MAX))

endmodule

bind bcd_countdown_timer_with_alarm bcdt_checker u_bcdt_checker (.*);
